// ----- sv/mgee_pkg.sv -----
// shared types, constants and helpers of the max-gradient edge enhancer
package mgee_pkg;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 16;
    localparam int H_W    = 32;
    localparam int OUT_W  = 31;
    localparam int DIFF_W = 33;
    localparam int WR_W   = 16;

    // configuration register indexes
    localparam logic REG_LAST_COL = 1'b0;
    localparam logic REG_LAST_ROW = 1'b1;

    localparam logic [COL_W-1:0] LAST_COL_RST = COL_W'(256);
    localparam logic [ROW_W-1:0] LAST_ROW_RST = ROW_W'(256);

    // result slots of one input transaction, in emission order
    localparam int SLOT_CENTER = 0;
    localparam int SLOT_RIGHT  = 1;
    localparam int SLOT_BOTTOM = 2;
    localparam int NUM_SLOTS   = 3;

    typedef struct packed {
        logic signed [H_W-1:0] height;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [OUT_W-1:0] new_height;
        logic             frame_last;
    } result_t;

    // everything the emitter needs to produce the results of one sample
    typedef struct packed {
        logic [COL_W-1:0]            col;
        logic [ROW_W-1:0]            row;
        logic [NUM_SLOTS-1:0]        mask;
        logic                        interior;
        logic signed [H_W-1:0]       base;
        logic signed [H_W-1:0]       mid;
        logic signed [H_W-1:0]       h;
        logic [3:0][DIFF_W-1:0]      diff;
    } bundle_t;

    function automatic logic [DIFF_W-1:0] abs_diff(logic signed [H_W-1:0] a,
                                                   logic signed [H_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

// ----- sv/mgee_stream_if.sv -----
// valid/ready stream channel carrying one payload per transaction
interface mgee_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/max_gradient_edge_enhance_unit.sv -----
// top level of the max-gradient edge enhancer: counters, window, line store access
// an accepted sample passes stage one, then the emitter's pending slots and output register
// throughput: one sample per cycle while results are taken; the single result port sends
// one result per cycle when ready, so samples with two or three results hold the input
// the line store is read when a sample is accepted and written when it leaves stage one
// reset: counters, window and handshake state clear at once; line memories are not
// cleared and stay undefined until written by the first rows of a frame
module max_gradient_edge_enhance_unit #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [mgee_pkg::WR_W-1:0]   wr_data,
    mgee_stream_if.sink                 pixel,
    mgee_stream_if.source               result
);

    localparam int AW = $clog2(LINE_DEPTH);

    // configuration
    logic [mgee_pkg::COL_W-1:0] last_col_reg;
    logic [mgee_pkg::ROW_W-1:0] last_row_reg;

    // position of the next sample, plus its line store address (column mod depth)
    logic [mgee_pkg::COL_W-1:0] col_reg;
    logic [mgee_pkg::COL_W-1:0] col_next;
    logic [mgee_pkg::ROW_W-1:0] row_reg;
    logic [mgee_pkg::ROW_W-1:0] row_next;
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              idx_next;

    // stage one: sample waiting for its line store read data
    logic                       s1_valid_reg;
    logic signed [mgee_pkg::H_W-1:0] s1_h_reg;
    logic [mgee_pkg::COL_W-1:0] s1_col_reg;
    logic [mgee_pkg::ROW_W-1:0] s1_row_reg;
    logic [AW-1:0]              s1_idx_reg;
    logic                       s1_fwd_reg;
    logic signed [mgee_pkg::H_W-1:0] s1_fwd_top_reg;
    logic signed [mgee_pkg::H_W-1:0] s1_fwd_mid_reg;

    // 3x2 window: [0],[1] top row at c-1,c-2; [2],[3] middle; [4],[5] bottom
    logic signed [mgee_pkg::H_W-1:0] win_reg [6];

    logic                       accept;
    logic                       s1_adv;
    logic                       emit_ready;
    logic signed [mgee_pkg::H_W-1:0] q_top;
    logic signed [mgee_pkg::H_W-1:0] q_mid;
    logic signed [mgee_pkg::H_W-1:0] top;
    logic signed [mgee_pkg::H_W-1:0] mid;
    mgee_pkg::bundle_t          bundle;

    assign s1_adv       = s1_valid_reg && emit_ready;
    assign pixel.ready  = !s1_valid_reg || s1_adv;
    assign accept       = pixel.valid && pixel.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= mgee_pkg::LAST_COL_RST;
            last_row_reg <= mgee_pkg::LAST_ROW_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mgee_pkg::REG_LAST_COL: last_col_reg <= wr_data[mgee_pkg::COL_W-1:0];
                mgee_pkg::REG_LAST_ROW: last_row_reg <= wr_data[mgee_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // raster counters, wrap compares use >= so a shrunk size still wraps
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        idx_next = idx_reg;
        if (accept)
        begin
            if (col_reg >= last_col_reg)
            begin
                col_next = '0;
                idx_next = '0;
                row_next = (row_reg >= last_row_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                idx_next = (idx_reg == AW'(LINE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        end
    end

    // stage one payload; a write to the same entry in the read cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_h_reg       <= pixel.data.height;
            s1_col_reg     <= col_reg;
            s1_row_reg     <= row_reg;
            s1_idx_reg     <= idx_reg;
            s1_fwd_reg     <= s1_adv && (s1_idx_reg == idx_reg);
            s1_fwd_top_reg <= mid;
            s1_fwd_mid_reg <= s1_h_reg;
        end
    end

    mgee_line_store #(
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (idx_reg),
        .rd_top  (q_top),
        .rd_mid  (q_mid),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_top  (mid),
        .wr_mid  (s1_h_reg)
    );

    assign top = s1_fwd_reg ? s1_fwd_top_reg : q_top;
    assign mid = s1_fwd_reg ? s1_fwd_mid_reg : q_mid;

    // window shifts once per sample as it leaves stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_adv)
        begin
            win_reg[1] <= win_reg[0];
            win_reg[0] <= top;
            win_reg[3] <= win_reg[2];
            win_reg[2] <= mid;
            win_reg[5] <= win_reg[4];
            win_reg[4] <= s1_h_reg;
        end
    end

    // results of this sample: center (c-1,r-1), right border (c,r-1), bottom (c,r)
    always_comb
    begin
        bundle.col  = s1_col_reg;
        bundle.row  = s1_row_reg;
        bundle.base = win_reg[2];
        bundle.mid  = mid;
        bundle.h    = s1_h_reg;
        bundle.mask[mgee_pkg::SLOT_CENTER] = (s1_row_reg != '0) && (s1_col_reg != '0);
        bundle.mask[mgee_pkg::SLOT_RIGHT]  = (s1_row_reg != '0)
                                          && (s1_col_reg >= last_col_reg);
        bundle.mask[mgee_pkg::SLOT_BOTTOM] = (s1_row_reg >= last_row_reg);
        // center point strictly inside the frame
        bundle.interior = (s1_col_reg >= mgee_pkg::COL_W'(2))
                       && (s1_row_reg >= mgee_pkg::ROW_W'(2))
                       && (s1_col_reg <= last_col_reg)
                       && (s1_row_reg <= last_row_reg);
        // opposite-neighbor pairs: two diagonals, horizontal, vertical
        bundle.diff[0] = mgee_pkg::abs_diff(s1_h_reg, win_reg[1]);
        bundle.diff[1] = mgee_pkg::abs_diff(win_reg[5], top);
        bundle.diff[2] = mgee_pkg::abs_diff(win_reg[3], mid);
        bundle.diff[3] = mgee_pkg::abs_diff(win_reg[0], win_reg[4]);
    end

    mgee_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_adv),
        .bundle     (bundle),
        .load_ready (emit_ready),
        .last_col   (last_col_reg),
        .last_row   (last_row_reg),
        .result     (result)
    );

endmodule

// ----- sv/mgee_line_store.sv -----
// two line memories with registered read port and one write port
module mgee_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic signed [mgee_pkg::H_W-1:0]   rd_top,
    output logic signed [mgee_pkg::H_W-1:0]   rd_mid,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic signed [mgee_pkg::H_W-1:0]   wr_top,
    input  logic signed [mgee_pkg::H_W-1:0]   wr_mid
);

    logic signed [mgee_pkg::H_W-1:0] two_above_mem [DEPTH];
    logic signed [mgee_pkg::H_W-1:0] above_mem [DEPTH];
    logic signed [mgee_pkg::H_W-1:0] rd_top_reg;
    logic signed [mgee_pkg::H_W-1:0] rd_mid_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            two_above_mem[wr_addr] <= wr_top;
            above_mem[wr_addr]     <= wr_mid;
        end
        if (rd_en)
        begin
            rd_top_reg <= two_above_mem[rd_addr];
            rd_mid_reg <= above_mem[rd_addr];
        end
    end

    assign rd_top = rd_top_reg;
    assign rd_mid = rd_mid_reg;

endmodule

// ----- sv/mgee_emitter.sv -----
// result stage: holds one sample's results and sends them out one per cycle while the receiver is ready
module mgee_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  mgee_pkg::bundle_t             bundle,
    output logic                          load_ready,
    input  logic [mgee_pkg::COL_W-1:0]    last_col,
    input  logic [mgee_pkg::ROW_W-1:0]    last_row,
    mgee_stream_if.source                 result
);

    mgee_pkg::bundle_t                bnd_reg;
    logic [mgee_pkg::NUM_SLOTS-1:0]   pend_reg;
    logic [mgee_pkg::NUM_SLOTS-1:0]   pend_next;
    logic [mgee_pkg::NUM_SLOTS-1:0]   sel;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    mgee_pkg::result_t                out_reg;
    mgee_pkg::result_t                out_next;
    logic                             out_free;
    logic                             emit;
    logic [mgee_pkg::DIFF_W-1:0]      m01;
    logic [mgee_pkg::DIFF_W-1:0]      m23;
    logic [mgee_pkg::DIFF_W-1:0]      mx;
    logic signed [mgee_pkg::DIFF_W:0] sum;
    logic signed [mgee_pkg::DIFF_W:0] val;
    logic [mgee_pkg::COL_W-1:0]       x;
    logic [mgee_pkg::ROW_W-1:0]       y;
    logic [mgee_pkg::NUM_SLOTS-1:0]   left;

    assign out_free = !out_valid_reg || result.ready;
    assign emit     = out_free && (pend_reg != '0);
    // lowest pending slot goes first
    assign sel      = pend_reg & (~pend_reg + 1'b1);
    assign left     = pend_reg & ~sel;
    assign load_ready = (pend_reg == '0) || (out_free && (left == '0));

    always_comb
    begin
        m01 = (bnd_reg.diff[0] > bnd_reg.diff[1]) ? bnd_reg.diff[0] : bnd_reg.diff[1];
        m23 = (bnd_reg.diff[2] > bnd_reg.diff[3]) ? bnd_reg.diff[2] : bnd_reg.diff[3];
        mx  = (m01 > m23) ? m01 : m23;
        sum = (mgee_pkg::DIFF_W+1)'(bnd_reg.base)
            + $signed({1'b0, mx});

        if (sel[mgee_pkg::SLOT_CENTER])
        begin
            val = bnd_reg.interior ? sum : (mgee_pkg::DIFF_W+1)'(bnd_reg.base);
            x   = bnd_reg.col - 1'b1;
            y   = bnd_reg.row - 1'b1;
        end
        else if (sel[mgee_pkg::SLOT_RIGHT])
        begin
            val = (mgee_pkg::DIFF_W+1)'(bnd_reg.mid);
            x   = bnd_reg.col;
            y   = bnd_reg.row - 1'b1;
        end
        else
        begin
            val = (mgee_pkg::DIFF_W+1)'(bnd_reg.h);
            x   = bnd_reg.col;
            y   = bnd_reg.row;
        end

        out_next.out_col    = x;
        out_next.out_row    = y;
        out_next.frame_last = (x == last_col) && (y == last_row);
        // clamp at zero, saturate at the top of the 31-bit range
        if (val[mgee_pkg::DIFF_W])
            out_next.new_height = '0;
        else if (val[mgee_pkg::DIFF_W-1:mgee_pkg::OUT_W] != '0)
            out_next.new_height = '1;
        else
            out_next.new_height = val[mgee_pkg::OUT_W-1:0];

        pend_next = emit ? left : pend_reg;
        if (load)
            pend_next = bundle.mask;

        out_valid_next = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bnd_reg <= bundle;
        if (emit)
            out_reg <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// ----- sv/mgee_checker.sv -----
// port-level checks of the edge enhancer and their binding to the top level
module mgee_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        wr_en,
    input logic                        wr_index,
    input logic [mgee_pkg::WR_W-1:0]   wr_data,
    input logic                        res_valid,
    input logic                        res_ready,
    input mgee_pkg::result_t           res_data
);

    logic [mgee_pkg::COL_W-1:0] lc_reg;
    logic [mgee_pkg::ROW_W-1:0] lr_reg;

    // shadow of the size registers as seen on the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg <= mgee_pkg::LAST_COL_RST;
            lr_reg <= mgee_pkg::LAST_ROW_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mgee_pkg::REG_LAST_COL: lc_reg <= wr_data[mgee_pkg::COL_W-1:0];
                mgee_pkg::REG_LAST_ROW: lr_reg <= wr_data[mgee_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.frame_last ==
            ((res_data.out_col == lc_reg) && (res_data.out_row == lr_reg)))
        else $error("frame_last does not match the last point");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind max_gradient_edge_enhance_unit mgee_checker u_mgee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

// ----- dv/tb_max_gradient_edge_enhance_unit.sv -----
// self-checking testbench of the max-gradient edge enhancer top level
module tb_max_gradient_edge_enhance_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          H_W           = mgee_pkg::H_W;
    localparam int          COL_W         = mgee_pkg::COL_W;
    localparam int          ROW_W         = mgee_pkg::ROW_W;
    localparam int          OUT_W         = mgee_pkg::OUT_W;
    localparam int          WR_W          = mgee_pkg::WR_W;

    localparam int          CLK_PERIOD    = 4;
    localparam int          RESET_CYCLES  = 12;
    localparam int          LINE_DEPTH    = 1024;
    // margin for a sample to pass stage one and the emitter after acceptance
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 24;
    // samples sent before a row is shrunk below the current column
    localparam int unsigned RESET_HEAD    = 6;
    localparam int unsigned WIDE_HEAD     = 20;
    localparam int unsigned RANDOM_ITEMS  = 90;
    localparam int          PRINT_LIMIT   = 100;
    // worst run is a few hundred samples with three results each and long stalls
    localparam longint      RUN_LIMIT_NS  = 3_000_000;

    localparam logic signed [H_W-1:0] H_MIN = 32'sh8000_0000;
    localparam logic signed [H_W-1:0] H_MAX = 32'sh7FFF_FFFF;
    localparam longint                OUT_TOP = 64'sd2147483647;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                wr_en;
    logic                wr_index;
    logic [WR_W-1:0]     wr_data;

    mgee_stream_if #(.T(mgee_pkg::in_item_t)) pixel_if ();
    mgee_stream_if #(.T(mgee_pkg::result_t))  result_if ();

    max_gradient_edge_enhance_unit #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data),
        .pixel   (pixel_if),
        .result  (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: size registers, raster position, line stores and
    // the 3x2 window of the two previous columns
    // ------------------------------------------------------------------
    int unsigned  size_last_col = mgee_pkg::LAST_COL_RST;
    int unsigned  size_last_row = mgee_pkg::LAST_ROW_RST;
    int unsigned  pos_col = 0;
    int unsigned  pos_row = 0;
    longint       row_above [LINE_DEPTH];
    longint       row_two_above [LINE_DEPTH];
    // [0],[1]: top row at c-1, c-2; [2],[3]: middle row; [4],[5]: bottom row
    longint       window_cols [6];

    mgee_pkg::result_t pending_points [$];
    int           mismatch_count = 0;
    int unsigned  burst_left = 0;

    initial
    begin
        foreach (row_above[i])
        begin
            row_above[i]     = 0;
            row_two_above[i] = 0;
        end
        foreach (window_cols[i])
        begin
            window_cols[i] = 0;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic longint abs_gap(input longint a, input longint b);
        longint d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    // queue one expected point: clamp at zero, saturate at the top of the range
    function automatic void queue_point(input int unsigned x, input int unsigned y,
                                        input longint v);
        mgee_pkg::result_t p;
        p.out_col    = x[COL_W-1:0];
        p.out_row    = y[ROW_W-1:0];
        if (v < 0)
            p.new_height = '0;
        else if (v > OUT_TOP)
            p.new_height = {OUT_W{1'b1}};
        else
            p.new_height = v[OUT_W-1:0];
        p.frame_last = (x == size_last_col) && (y == size_last_row);
        pending_points.push_back(p);
    endfunction

    // one accepted sample: emit the points it completes, then advance the window
    function automatic void compute_enhanced_points(input logic signed [H_W-1:0] h);
        longint      hv;
        longint      top;
        longint      mid;
        longint      v;
        longint      m;
        int unsigned c;
        int unsigned r;
        int unsigned x;
        int unsigned y;
        int unsigned idx;
        c   = pos_col;
        r   = pos_row;
        idx = c % LINE_DEPTH;
        hv  = h;
        top = row_two_above[idx];
        mid = row_above[idx];

        // center point one column to the left in the row above
        if (r >= 1 && c >= 1)
        begin
            x = c - 1;
            y = r - 1;
            v = window_cols[2];
            if (x > 0 && y > 0 && x < size_last_col && y < size_last_row)
            begin
                m = abs_gap(hv, window_cols[1]);
                if (abs_gap(window_cols[5], top) > m)
                    m = abs_gap(window_cols[5], top);
                if (abs_gap(window_cols[3], mid) > m)
                    m = abs_gap(window_cols[3], mid);
                if (abs_gap(window_cols[0], window_cols[4]) > m)
                    m = abs_gap(window_cols[0], window_cols[4]);
                v += m;
            end
            queue_point(x, y, v);
        end
        // right border of the row above
        if (r >= 1 && c >= size_last_col)
            queue_point(c, r - 1, mid);
        // bottom border row passes straight through
        if (r >= size_last_row)
            queue_point(c, r, hv);

        window_cols[1] = window_cols[0];
        window_cols[0] = top;
        window_cols[3] = window_cols[2];
        window_cols[2] = mid;
        window_cols[5] = window_cols[4];
        window_cols[4] = hv;
        row_two_above[idx] = mid;
        row_above[idx]     = hv;

        if (c >= size_last_col)
        begin
            pos_col = 0;
            if (r >= size_last_row)
                pos_row = 0;
            else
                pos_row = (r + 1) & 16'hFFFF;
        end
        else
        begin
            pos_col = (c + 1) & 10'h3FF;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers; every task is entered and left at a falling edge
    // ------------------------------------------------------------------

    // one sample transaction; the sender runs in bursts with random gaps
    task automatic send_height(input logic signed [H_W-1:0] h);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                pixel_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        pixel_if.valid       <= 1'b1;
        pixel_if.data.height <= h;
        do @(posedge clk); while (!pixel_if.ready);
        compute_enhanced_points(h);
        burst_left--;
        @(negedge clk);
    endtask

    // hold the sender until every expected point has arrived, then let the
    // pipeline settle since row-zero samples leave no trace in the queue
    task automatic wait_results_drained();
        pixel_if.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending_points.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // both size registers back to back, only while the block is idle
    task automatic set_size(input logic [COL_W-1:0] lc, input logic [ROW_W-1:0] lr);
        wr_en    <= 1'b1;
        wr_index <= mgee_pkg::REG_LAST_COL;
        wr_data  <= WR_W'(lc);
        @(negedge clk);
        wr_index <= mgee_pkg::REG_LAST_ROW;
        wr_data  <= WR_W'(lr);
        @(negedge clk);
        wr_en    <= 1'b0;
        size_last_col = lc;
        size_last_row = lr;
    endtask

    // mix of small values (negative clamp), extremes, near-saturation and full range
    function automatic logic signed [H_W-1:0] rand_height();
        case ($urandom_range(0, 7))
            0, 1:    return H_W'(int'($urandom_range(0, 200)) - 100);
            2, 3:    return $urandom;
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       return H_MIN;
                    1:       return H_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            5:       return H_MAX - H_W'($urandom_range(0, 1000));
            6:       return H_MIN + H_W'($urandom_range(0, 1000));
            default: return H_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic send_random_items(input int unsigned count);
        repeat (count) send_height(rand_height());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset size 257 x 257: start row zero under the reset registers, then
    // shrink the row below the current column and close the frame after row one
    task automatic test_reset_size();
        send_random_items(RESET_HEAD);
        wait_results_drained();
        set_size(COL_W'(RESET_HEAD - 1), 1);
        send_random_items(RESET_HEAD + 1);
        wait_results_drained();
    endtask

    // smallest frame: 2 x 2, every point is a border point
    task automatic test_min_frame();
        set_size(1, 1);
        send_height(H_MIN);
        send_height(-1);
        send_height(H_MAX);
        send_height(-5);
        wait_results_drained();
    endtask

    // 5 x 4 frame of extremes: saturation, widest differences, border clamp
    task automatic test_directed_frame();
        logic signed [H_W-1:0] grid [20];
        grid = '{32'sd0,  -32'sd1,  H_MAX,    H_MIN,    32'sd5,
                 H_MIN,   H_MAX,    32'sd100, -32'sd3,  32'sd2,
                 H_MAX,   H_MIN,    -32'sd1,  H_MIN,    -32'sd4,
                 32'sd1,  H_MAX,    -32'sd2,  32'sd3,   H_MIN};
        set_size(4, 3);
        foreach (grid[i])
        begin
            send_height(grid[i]);
        end
        wait_results_drained();
    endtask

    // tallest setting: interior test against last_row at its top value,
    // then close the frame at a row boundary
    task automatic test_tall_frame();
        set_size(2, 16'hFFFF);
        send_random_items(3 * 5);
        wait_results_drained();
        set_size(2, 5);
        send_random_items(3);
        wait_results_drained();
    endtask

    // widest setting: start row zero, then shrink the row below the current
    // column so it wraps at once, and finish a two-row frame
    task automatic test_wide_frame();
        set_size(10'h3FF, 1);
        send_random_items(WIDE_HEAD);
        wait_results_drained();
        set_size(COL_W'(WIDE_HEAD - 1), 1);
        send_random_items(WIDE_HEAD + 1);
        wait_results_drained();
    endtask

    // random small frames sized to the remaining budget; the first one is
    // paused mid-frame until drained
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned remaining;
        int unsigned lc;
        int unsigned lr;
        int unsigned lr_cap;
        int unsigned n;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            remaining = RANDOM_ITEMS - sent;
            lc = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
            lr = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            // fit the frame to the remaining budget where it can, but keep at least two rows
            lr_cap = remaining / (lc + 1);
            if (lr_cap < 2)
                lr_cap = 2;
            if (lr > lr_cap - 1)
                lr = lr_cap - 1;
            n  = (lc + 1) * (lr + 1);
            set_size(COL_W'(lc), ROW_W'(lr));
            if (!paused)
            begin
                send_random_items(n / 2);
                wait_results_drained();
                send_random_items(n - n / 2);
                paused = 1'b1;
            end
            else
            begin
                send_random_items(n);
            end
            wait_results_drained();
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // result side: receiver stall pattern and checker
    // ------------------------------------------------------------------

    // modes: always ready, coin flip, periodic hole, long runs high and low
    initial
    begin : ready_pattern
        int unsigned mode;
        int unsigned hold;
        int unsigned cyc;
        mode = 0;
        hold = 0;
        cyc  = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cyc % 96 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                case (mode)
                    0:       result_if.ready <= 1'b1;
                    1:       result_if.ready <= $urandom_range(0, 1);
                    2:       result_if.ready <= (cyc % 5) != 3;
                    default:
                    begin
                        if (result_if.ready)
                        begin
                            result_if.ready <= 1'b0;
                            hold = $urandom_range(1, 12);
                        end
                        else
                        begin
                            result_if.ready <= 1'b1;
                            hold = $urandom_range(1, 16);
                        end
                    end
                endcase
            end
        end
    end

    // sample the transaction at the rising edge and compare at the falling edge, so
    // the sender's prediction of the same edge is already queued
    initial
    begin : result_checker
        mgee_pkg::result_t got;
        mgee_pkg::result_t want;
        bit                fired;
        forever
        begin
            @(posedge clk);
            fired = (rst_n === 1'b1) && result_if.valid && result_if.ready;
            got   = result_if.data;
            @(negedge clk);
            if (fired)
            begin
                if (pending_points.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result col %0d row %0d",
                                              got.out_col, got.out_row));
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (got.out_col !== want.out_col)
                        report_mismatch($sformatf("out_col %0d, expected %0d",
                                                  got.out_col, want.out_col));
                    if (got.out_row !== want.out_row)
                        report_mismatch($sformatf("out_row %0d, expected %0d",
                                                  got.out_row, want.out_row));
                    if (got.new_height !== want.new_height)
                        report_mismatch($sformatf("new_height %0h at (%0d,%0d), expected %0h",
                                                  got.new_height, want.out_col,
                                                  want.out_row, want.new_height));
                    if (got.frame_last !== want.frame_last)
                        report_mismatch($sformatf("frame_last %0b at (%0d,%0d), expected %0b",
                                                  got.frame_last, want.out_col,
                                                  want.out_row, want.frame_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = mgee_pkg::REG_LAST_COL;
        wr_data              = '0;
        pixel_if.valid       = 1'b0;
        pixel_if.data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset size must run before any register write
        test_reset_size();
        test_min_frame();
        test_directed_frame();
        test_tall_frame();
        test_wide_frame();
        test_random_frames();

        wait_results_drained();
        // catch late or spurious results
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_points.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS * 1ns);
        $display("TEST FAILED");
        $finish;
    end

endmodule
